// ----- rtl/bedlp_pkg.sv -----
// shared types and constants for the button event debounce block
// no dependencies
`default_nettype none

package bedlp_pkg;

    localparam int unsigned TIME_W  = 32;
    localparam int unsigned CFG_W   = 16;
    localparam int unsigned CODE_W  = 3;
    localparam int unsigned NUM_BTN = 3;
    localparam int unsigned PADDR_W = 3;
    localparam int unsigned PDATA_W = 32;

    localparam logic [CFG_W-1:0] LOCKOUT_RESET    = 16'd50;
    localparam logic [CFG_W-1:0] LONG_PRESS_RESET = 16'd3000;

    // register index, taken from paddr[2]
    typedef enum logic
    {
        REG_LOCKOUT    = 1'b0,
        REG_LONG_PRESS = 1'b1
    } reg_idx_t;

    typedef enum logic [CODE_W-1:0]
    {
        EV_NONE      = 3'd0,
        EV_MENU      = 3'd1,
        EV_UP        = 3'd2,
        EV_DOWN      = 3'd3,
        EV_SEL_SHORT = 3'd4,
        EV_SEL_LONG  = 3'd5
    } event_t;

    // one poll word; levels bit0 menu, bit1 up, bit2 down
    typedef struct packed
    {
        logic [TIME_W-1:0]  now_ms;
        logic [NUM_BTN-1:0] levels;
        logic               select_level;
    } poll_t;

endpackage

`default_nettype wire

// ----- rtl/bedlp_eval.sv -----
// poll evaluation: lockout check, press scan, select timing and the state they keep
// depends on bedlp_pkg
`default_nettype none

module bedlp_eval
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         fire,
    input  wire bedlp_pkg::poll_t             poll,
    input  wire logic [bedlp_pkg::CFG_W-1:0]  lockout_ms,
    input  wire logic [bedlp_pkg::CFG_W-1:0]  long_press_ms,
    output bedlp_pkg::event_t                 event_code
);

    logic [bedlp_pkg::TIME_W-1:0]  last_time_reg;
    logic [bedlp_pkg::TIME_W-1:0]  last_time_next;
    logic [bedlp_pkg::NUM_BTN-1:0] held_reg;
    logic [bedlp_pkg::NUM_BTN-1:0] held_next;
    logic                          sel_held_reg;
    logic                          sel_held_next;
    logic [bedlp_pkg::TIME_W-1:0]  sel_start_reg;
    logic [bedlp_pkg::TIME_W-1:0]  sel_start_next;

    logic [bedlp_pkg::TIME_W-1:0]  since_last;
    logic [bedlp_pkg::TIME_W-1:0]  hold_time;
    logic                          honored;
    logic                          is_long;
    logic                          found;

    // wrapping distances
    assign since_last = poll.now_ms - last_time_reg;
    assign hold_time  = poll.now_ms - sel_start_reg;
    assign honored    = since_last >= {{(bedlp_pkg::TIME_W-bedlp_pkg::CFG_W){1'b0}}, lockout_ms};
    assign is_long    = hold_time >= {{(bedlp_pkg::TIME_W-bedlp_pkg::CFG_W){1'b0}}, long_press_ms};

    always_comb
    begin
        last_time_next = last_time_reg;
        held_next      = held_reg;
        sel_held_next  = sel_held_reg;
        sel_start_next = sel_start_reg;
        event_code     = bedlp_pkg::EV_NONE;
        found          = 1'b0;
        if (honored)
        begin
            // priority scan; stops at the first new press
            for (int k = 0; k < bedlp_pkg::NUM_BTN; k++)
            begin
                if (!found)
                begin
                    if (poll.levels[k] && !held_reg[k])
                    begin
                        found          = 1'b1;
                        held_next[k]   = 1'b1;
                        last_time_next = poll.now_ms;
                        event_code     = bedlp_pkg::event_t'(3'(k) + 3'd1);
                    end
                    else if (!poll.levels[k])
                    begin
                        held_next[k] = 1'b0;
                    end
                end
            end
            if (!found)
            begin
                if (poll.select_level && !sel_held_reg)
                begin
                    sel_held_next  = 1'b1;
                    sel_start_next = poll.now_ms;
                end
                else if (!poll.select_level && sel_held_reg)
                begin
                    sel_held_next  = 1'b0;
                    last_time_next = poll.now_ms;
                    event_code     = is_long ? bedlp_pkg::EV_SEL_LONG
                                             : bedlp_pkg::EV_SEL_SHORT;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_time_reg <= '0;
            held_reg      <= '0;
            sel_held_reg  <= 1'b0;
            sel_start_reg <= '0;
        end
        else if (fire)
        begin
            last_time_reg <= last_time_next;
            held_reg      <= held_next;
            sel_held_reg  <= sel_held_next;
            sel_start_reg <= sel_start_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/button_event_debounce_long_press.sv -----
// button event debounce with long-press select: top level
// the event word is worked out from the input word register and registered in the result register
// throughput: one poll word per cycle while out_ready is high; a waiting result takes one more
// poll word into the input register and then holds in_ready low
// reset: rst_n clears all button state and restores lockout 50 ms and long press 3000 ms
// depends on bedlp_pkg and bedlp_eval
`default_nettype none

module button_event_debounce_long_press
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,

    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic [bedlp_pkg::TIME_W-1:0]     now_ms,
    input  wire logic                             menu_level,
    input  wire logic                             up_level,
    input  wire logic                             down_level,
    input  wire logic                             select_level,

    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic [bedlp_pkg::CODE_W-1:0]          event_code,

    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [bedlp_pkg::PADDR_W-1:0]    paddr,
    input  wire logic [bedlp_pkg::PDATA_W-1:0]    pwdata,
    output logic [bedlp_pkg::PDATA_W-1:0]         prdata,
    output logic                                  pready
);

    logic [bedlp_pkg::CFG_W-1:0] lockout_reg;
    logic [bedlp_pkg::CFG_W-1:0] long_press_reg;
    logic                        cfg_write;
    bedlp_pkg::reg_idx_t         cfg_idx;

    logic                        s1_valid_reg;
    bedlp_pkg::poll_t            s1_poll_reg;
    logic                        out_valid_reg;
    logic [bedlp_pkg::CODE_W-1:0] event_code_reg;

    logic                        advance;
    logic                        fire;
    bedlp_pkg::event_t           eval_code;

    // config port
    assign pready    = 1'b1;
    assign cfg_idx   = bedlp_pkg::reg_idx_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lockout_reg    <= bedlp_pkg::LOCKOUT_RESET;
            long_press_reg <= bedlp_pkg::LONG_PRESS_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                bedlp_pkg::REG_LOCKOUT:    lockout_reg    <= pwdata[bedlp_pkg::CFG_W-1:0];
                bedlp_pkg::REG_LONG_PRESS: long_press_reg <= pwdata[bedlp_pkg::CFG_W-1:0];
                default:                   lockout_reg    <= lockout_reg;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            bedlp_pkg::REG_LOCKOUT:
                prdata = {{(bedlp_pkg::PDATA_W-bedlp_pkg::CFG_W){1'b0}}, lockout_reg};
            bedlp_pkg::REG_LONG_PRESS:
                prdata = {{(bedlp_pkg::PDATA_W-bedlp_pkg::CFG_W){1'b0}}, long_press_reg};
            default:
                prdata = '0;
        endcase
    end

    // input word stage moves on whenever the result register is free or draining
    assign advance  = !out_valid_reg || out_ready;
    assign fire     = s1_valid_reg && advance;
    assign in_ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_poll_reg.now_ms       <= now_ms;
            s1_poll_reg.levels       <= {down_level, up_level, menu_level};
            s1_poll_reg.select_level <= select_level;
        end
    end

    bedlp_eval u_eval
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (fire),
        .poll          (s1_poll_reg),
        .lockout_ms    (lockout_reg),
        .long_press_ms (long_press_reg),
        .event_code    (eval_code)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            event_code_reg <= eval_code;
        end
    end

    assign out_valid  = out_valid_reg;
    assign event_code = event_code_reg;

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
// testbench for button_event_debounce_long_press: directed table, then random polls
// checks each event word against table or predictor; depends on bedlp_pkg and the rtl
`timescale 1ns / 1ps

module tb;

    localparam int LIMIT       = 400000;
    localparam int LONG_HOLD   = 400;
    localparam int NUM_PHASES  = 8;
    localparam int PHASE_POLLS = 250;
    localparam int NUM_ROWS    = 24;

    // one directed poll; want is only used where typed is set
    typedef struct packed
    {
        logic [bedlp_pkg::TIME_W-1:0]  t;
        logic [bedlp_pkg::NUM_BTN-1:0] lv;
        logic                          sel;
        logic                          typed;
        bedlp_pkg::event_t             want;
    } poll_row_t;

    logic                            clk;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_ready;
    logic [bedlp_pkg::TIME_W-1:0]    now_ms;
    logic                            menu_level;
    logic                            up_level;
    logic                            down_level;
    logic                            select_level;
    logic                            out_valid;
    logic                            out_ready;
    logic [bedlp_pkg::CODE_W-1:0]    event_code;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [bedlp_pkg::PADDR_W-1:0]   paddr;
    logic [bedlp_pkg::PDATA_W-1:0]   pwdata;
    logic [bedlp_pkg::PDATA_W-1:0]   prdata;
    logic                            pready;

    // predictor copy of the block's registers and state
    logic [bedlp_pkg::CFG_W-1:0]     lockout_cfg;
    logic [bedlp_pkg::CFG_W-1:0]     long_press_cfg;
    logic [bedlp_pkg::TIME_W-1:0]    exp_last_event_ms;
    logic [bedlp_pkg::NUM_BTN-1:0]   exp_held_marks;
    logic                            exp_select_held;
    logic [bedlp_pkg::TIME_W-1:0]    exp_select_start_ms;

    // physical button picture carried between random polls
    logic [bedlp_pkg::TIME_W-1:0]    now_cursor;
    logic [bedlp_pkg::NUM_BTN-1:0]   btn_state;
    logic                            sel_state;

    bedlp_pkg::event_t               pending_events [$];
    bedlp_pkg::event_t               want_ev;
    int                              cycles;
    int                              failures;
    int                              polls_sent;
    int                              events_seen;
    bit                              sink_stalls;
    bit                              hold_req;

    poll_row_t directed_rows [NUM_ROWS] = '{
        '{32'd0,          3'b001, 1'b0, 1'b1, bedlp_pkg::EV_NONE},
        '{32'd49,         3'b001, 1'b0, 1'b1, bedlp_pkg::EV_NONE},
        '{32'd50,         3'b001, 1'b0, 1'b1, bedlp_pkg::EV_MENU},
        '{32'd60,         3'b011, 1'b0, 1'b0, bedlp_pkg::EV_NONE},
        '{32'd100,        3'b011, 1'b0, 1'b0, bedlp_pkg::EV_NONE},
        '{32'd150,        3'b111, 1'b0, 1'b0, bedlp_pkg::EV_NONE},
        '{32'd200,        3'b111, 1'b1, 1'b0, bedlp_pkg::EV_NONE},
        '{32'd201,        3'b111, 1'b1, 1'b0, bedlp_pkg::EV_NONE},
        '{32'd250,        3'b110, 1'b1, 1'b0, bedlp_pkg::EV_NONE},
        '{32'd251,        3'b001, 1'b1, 1'b0, bedlp_pkg::EV_NONE},
        '{32'd301,        3'b011, 1'b1, 1'b0, bedlp_pkg::EV_NONE},
        '{32'd400,        3'b011, 1'b0, 1'b0, bedlp_pkg::EV_NONE},
        '{32'd500,        3'b000, 1'b1, 1'b0, bedlp_pkg::EV_NONE},
        '{32'd3500,       3'b000, 1'b0, 1'b1, bedlp_pkg::EV_SEL_LONG},
        '{32'd3550,       3'b000, 1'b1, 1'b0, bedlp_pkg::EV_NONE},
        '{32'd6549,       3'b000, 1'b0, 1'b1, bedlp_pkg::EV_SEL_SHORT},
        '{32'hFFFF_FFF0,  3'b000, 1'b1, 1'b0, bedlp_pkg::EV_NONE},
        '{32'h0000_0BA8,  3'b000, 1'b0, 1'b0, bedlp_pkg::EV_NONE},
        '{32'h0000_0BD9,  3'b001, 1'b0, 1'b1, bedlp_pkg::EV_NONE},
        '{32'hFFFF_FFFF,  3'b111, 1'b1, 1'b0, bedlp_pkg::EV_NONE},
        '{32'h0000_0031,  3'b111, 1'b1, 1'b0, bedlp_pkg::EV_NONE},
        '{32'h0000_0100,  3'b000, 1'b1, 1'b0, bedlp_pkg::EV_NONE},
        '{32'h0000_0200,  3'b100, 1'b0, 1'b0, bedlp_pkg::EV_NONE},
        '{32'h0000_0300,  3'b000, 1'b0, 1'b0, bedlp_pkg::EV_NONE}
    };

    button_event_debounce_long_press uut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .now_ms       (now_ms),
        .menu_level   (menu_level),
        .up_level     (up_level),
        .down_level   (down_level),
        .select_level (select_level),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .event_code   (event_code),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // works out the event of one honored or suppressed poll and updates state
    function automatic bedlp_pkg::event_t predict_event(
        logic [bedlp_pkg::TIME_W-1:0] t, logic [bedlp_pkg::NUM_BTN-1:0] lv, logic sel);
        logic [bedlp_pkg::TIME_W-1:0] gap;
        logic [bedlp_pkg::TIME_W-1:0] hold;
        bedlp_pkg::event_t            ev;
        gap = t - exp_last_event_ms;
        if (gap < bedlp_pkg::TIME_W'(lockout_cfg))
            return bedlp_pkg::EV_NONE;
        for (int k = 0; k < bedlp_pkg::NUM_BTN; k++)
        begin
            if (lv[k] && !exp_held_marks[k])
            begin
                exp_held_marks[k] = 1'b1;
                exp_last_event_ms = t;
                case (k)
                    0: ev = bedlp_pkg::EV_MENU;
                    1: ev = bedlp_pkg::EV_UP;
                    default: ev = bedlp_pkg::EV_DOWN;
                endcase
                return ev;
            end
            if (!lv[k])
                exp_held_marks[k] = 1'b0;
        end
        if (sel && !exp_select_held)
        begin
            exp_select_held = 1'b1;
            exp_select_start_ms = t;
        end
        else if (!sel && exp_select_held)
        begin
            hold = t - exp_select_start_ms;
            exp_select_held = 1'b0;
            exp_last_event_ms = t;
            return (hold >= bedlp_pkg::TIME_W'(long_press_cfg)) ? bedlp_pkg::EV_SEL_LONG
                                                                : bedlp_pkg::EV_SEL_SHORT;
        end
        return bedlp_pkg::EV_NONE;
    endfunction

    // starts and ends at a falling edge; in_valid drops after each accepted word
    task automatic send_poll(input logic [bedlp_pkg::TIME_W-1:0] t,
                             input logic [bedlp_pkg::NUM_BTN-1:0] lv,
                             input logic sel, input bit typed, input bedlp_pkg::event_t want,
                             input bit gaps);
        bedlp_pkg::event_t ev;
        now_ms       = t;
        menu_level   = lv[0];
        up_level     = lv[1];
        down_level   = lv[2];
        select_level = sel;
        in_valid     = 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        ev = predict_event(t, lv, sel);
        pending_events.push_back(typed ? want : ev);
        polls_sent++;
        @(negedge clk);
        in_valid = 1'b0;
        if (gaps && $urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 16)) @(negedge clk);
    endtask

    task automatic write_reg(input bedlp_pkg::reg_idx_t idx,
                             input logic [bedlp_pkg::CFG_W-1:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        // upper bits are junk, only the low half counts
        pwdata  = {16'($urandom), value};
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (idx == bedlp_pkg::REG_LOCKOUT)
            lockout_cfg = value;
        else
            long_press_cfg = value;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    // button sequences mostly follow a press, hold, release pattern with times near the
    // lockout and long-press edges; one poll in eight is plain noise
    task automatic send_random_polls(input int count, input bit gaps);
        logic [bedlp_pkg::TIME_W-1:0] t;
        logic [bedlp_pkg::NUM_BTN-1:0] btn;
        logic sel;
        int unsigned span;
        int mode;
        t   = now_cursor;
        btn = btn_state;
        sel = sel_state;
        span = 32'(lockout_cfg) * 3 / 2 + 4;
        repeat (count)
        begin
            mode = $urandom_range(0, 15);
            case (mode)
                8, 9: t = t + $urandom_range(0, 2);
                10: t = exp_last_event_ms + bedlp_pkg::TIME_W'(lockout_cfg) - 1
                        + $urandom_range(0, 1);
                11:
                begin
                    if (exp_select_held)
                        t = exp_select_start_ms + bedlp_pkg::TIME_W'(long_press_cfg) - 1
                            + $urandom_range(0, 1);
                    else
                        t = t + $urandom_range(0, 32'(long_press_cfg) + 32'(lockout_cfg));
                end
                12: t = t + $urandom_range(0, 2 * 32'(long_press_cfg) + 2);
                13: t = $urandom;
                default: t = t + $urandom_range(0, span);
            endcase
            if ($urandom_range(0, 7) == 0)
            begin
                btn = 3'($urandom);
                sel = 1'($urandom);
            end
            else
            begin
                for (int k = 0; k < bedlp_pkg::NUM_BTN; k++)
                    if ($urandom_range(0, 3) == 0)
                        btn[k] = ~btn[k];
                if ($urandom_range(0, 3) == 0)
                    sel = ~sel;
            end
            send_poll(t, btn, sel, 1'b0, bedlp_pkg::EV_NONE, gaps);
        end
        now_cursor = t;
        btn_state  = btn;
        sel_state  = sel;
    endtask

    // event checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_events.size() == 0)
            begin
                $error("event_code %0d arrived with no poll pending", event_code);
                failures++;
            end
            else
            begin
                want_ev = pending_events.pop_front();
                if (event_code !== want_ev)
                begin
                    $error("event_code mismatch: expected %0d, got %0d", want_ev, event_code);
                    failures++;
                end
                if (want_ev != bedlp_pkg::EV_NONE)
                    events_seen++;
            end
        end
    end

    // receiver side: random stalls plus one long hold-off on request
    initial
    begin
        out_ready = 1'b0;
        while (!rst_n)
            @(negedge clk);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ready = 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                hold_req = 1'b0;
            end
            else if (sink_stalls && $urandom_range(0, 5) == 0)
            begin
                out_ready = 1'b0;
                repeat ($urandom_range(1, 16)) @(negedge clk);
            end
            out_ready = 1'b1;
        end
    end

    initial
    begin
        logic [bedlp_pkg::CFG_W-1:0] lockout_plan [NUM_PHASES];
        logic [bedlp_pkg::CFG_W-1:0] long_plan [NUM_PHASES];
        bit                          last_phase;
        cycles       = 0;
        failures     = 0;
        polls_sent   = 0;
        events_seen  = 0;
        sink_stalls  = 1'b0;
        hold_req     = 1'b0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        now_ms       = '0;
        menu_level   = 1'b0;
        up_level     = 1'b0;
        down_level   = 1'b0;
        select_level = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;

        lockout_cfg         = bedlp_pkg::LOCKOUT_RESET;
        long_press_cfg      = bedlp_pkg::LONG_PRESS_RESET;
        exp_last_event_ms   = '0;
        exp_held_marks      = '0;
        exp_select_held     = 1'b0;
        exp_select_start_ms = '0;
        now_cursor          = '0;
        btn_state           = '0;
        sel_state           = 1'b0;

        lockout_plan = '{16'd50, 16'd0, 16'hFFFF, 16'd0, 16'd10,
                         16'($urandom_range(0, 300)), 16'($urandom), 16'd50};
        long_plan    = '{16'd3000, 16'd0, 16'hFFFF, 16'hFFFF, 16'd100,
                         16'($urandom_range(0, 2000)), 16'($urandom), 16'd3000};

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        sink_stalls = 1'b1;
        foreach (directed_rows[i])
            send_poll(directed_rows[i].t, directed_rows[i].lv, directed_rows[i].sel,
                      directed_rows[i].typed, directed_rows[i].want, 1'b1);
        now_cursor = directed_rows[NUM_ROWS-1].t;
        btn_state  = directed_rows[NUM_ROWS-1].lv;
        sel_state  = directed_rows[NUM_ROWS-1].sel;

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_idle();
            write_reg(bedlp_pkg::REG_LOCKOUT, lockout_plan[p]);
            write_reg(bedlp_pkg::REG_LONG_PRESS, long_plan[p]);
            last_phase  = (p == NUM_PHASES - 1);
            sink_stalls = !last_phase && $urandom_range(0, 3) != 0;
            // back-to-back words against a stalled receiver fill the pipe
            if (p == 3)
                hold_req = 1'b1;
            send_random_polls(PHASE_POLLS,
                              !last_phase && p != 3 && $urandom_range(0, 3) != 0);
        end

        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (pending_events.size() != 0)
        begin
            $error("%0d event words never arrived", pending_events.size());
            failures++;
        end

        $display("%0d polls over %0d register settings, %0d of them raised a button event",
                 polls_sent, NUM_PHASES + 1, events_seen);
        $display("lockout and long-press edges, timestamp wrap and a long output stall were hit");
        if (failures == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/bedlp_pkg.sv
rtl/bedlp_eval.sv
rtl/button_event_debounce_long_press.sv
bench/tb.sv
